[design/assert_macros.svh]
// Assertion helper macros for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[design/tcs_pkg.sv]
// ----------------------------------------------------------------------------
// tcs_pkg
// Types and constants shared by the textured column shader modules.
// ----------------------------------------------------------------------------
package tcs_pkg;
  localparam int TEX_SIZE     = 64;
  localparam int NUM_TEXTURES = 4;
  localparam int SCREEN_W     = 1024;
  localparam int SCREEN_H     = 1024;
  localparam int TEX_W        = $clog2(TEX_SIZE);
  localparam int WALL_W       = 2;
  localparam int ADDR_W       = WALL_W + 2 * TEX_W;
  localparam int DEPTH        = NUM_TEXTURES * TEX_SIZE * TEX_SIZE;
  localparam int DIV_STEPS    = 19;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_EMIT  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [23:0] FOG_LIMIT = 24'd1280;

  typedef struct packed {
    logic tex_write;
    logic col_start;
    logic emit;
    logic div_start;
    logic div_step;
  } tcs_cmd_t;

  typedef struct packed {
    logic row_left;
    logic fog_on;
  } tcs_status_t;
endpackage

[design/tcs_datapath.sv]
// ----------------------------------------------------------------------------
// tcs_datapath
// Column registers, texture memory and a restoring divider for fog.
// ----------------------------------------------------------------------------
module tcs_datapath (
  input  logic                 clk,
  input  tcs_pkg::tcs_cmd_t    cmd,
  input  logic                 rst_n,
  input  logic [1:0]           in_wall_side,
  input  logic [5:0]           in_tex_col,
  input  logic [5:0]           in_tex_row,
  input  logic [23:0]          in_texel,
  input  logic [9:0]           in_screen_col,
  input  logic [9:0]           in_row_start,
  input  logic [10:0]          in_row_end,
  input  logic [31:0]          in_tex_pos,
  input  logic [31:0]          in_tex_step,
  input  logic [23:0]          in_distance,
  output tcs_pkg::tcs_status_t status,
  output logic [9:0]           pix_x,
  output logic [9:0]           pix_y,
  output logic [23:0]          pix_color,
  output logic                 pix_last
);
  import tcs_pkg::*;

  logic [23:0] mem [DEPTH];
  logic [23:0] rd_r;
  logic        wall_ok_r;
  logic [31:0] pos_r, step_r;
  logic [10:0] row_r, end_r;
  logic [1:0]  wall_r;
  logic [TEX_W-1:0] tx_r;
  logic [9:0]  sx_r;
  logic [23:0] dist_r;
  logic [10:0] rend;
  logic [ADDR_W-1:0] waddr, raddr;

  assign waddr = {in_wall_side, in_tex_row[TEX_W-1:0], in_tex_col[TEX_W-1:0]};
  assign raddr = {wall_r, pos_r[16 +: TEX_W], tx_r};

  // Write texels and register the read for the pixel in flight
  always_ff @(posedge clk) begin
    if (cmd.tex_write && (32'(in_wall_side) < 32'(NUM_TEXTURES))) begin
      mem[waddr] <= in_texel;
    end
    if (cmd.emit) begin
      rd_r      <= mem[raddr];
      wall_ok_r <= 32'(wall_r) < 32'(NUM_TEXTURES);
    end
  end

  always_comb begin
    rend = (in_row_end > 11'(SCREEN_H)) ? 11'(SCREEN_H) : in_row_end;
    if (32'(in_screen_col) >= 32'(SCREEN_W)) rend = {1'b0, in_row_start};
  end

  // Latch column state and advance per pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; step_r <= '0; row_r <= '0; end_r <= '0;
      wall_r <= '0; tx_r <= '0; sx_r <= '0; dist_r <= '0;
    end else if (cmd.col_start) begin
      pos_r <= in_tex_pos; step_r <= in_tex_step;
      row_r <= {1'b0, in_row_start}; end_r <= rend;
      wall_r <= in_wall_side; tx_r <= in_tex_col[TEX_W-1:0];
      sx_r <= in_screen_col; dist_r <= in_distance;
    end else if (cmd.emit) begin
      pos_r <= pos_r + step_r;
      row_r <= row_r + 11'd1;
      pix_x <= sx_r;
      pix_y <= row_r[9:0];
      pix_last <= (row_r + 11'd1) == end_r;
    end
  end

  assign status.row_left = row_r < end_r;
  assign status.fog_on   = dist_r >= FOG_LIMIT;

  // Restoring division of c*1280 by distance, three channels in parallel
  logic [23:0] rem_r [3];
  logic [18:0] num_r [3];
  logic [7:0]  quo_r [3];
  logic [23:0] src;

  assign src = wall_ok_r ? rd_r : 24'd0;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= 19'(src[8*i +: 8]) * 19'd1280;
        rem_r[i] <= '0;
        quo_r[i] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        logic [24:0] t;
        t = {rem_r[i], num_r[i][18]};
        if (t >= {1'b0, dist_r}) begin
          rem_r[i] <= 24'(t - {1'b0, dist_r});
          quo_r[i] <= {quo_r[i][6:0], 1'b1};
        end else begin
          rem_r[i] <= t[23:0];
          quo_r[i] <= {quo_r[i][6:0], 1'b0};
        end
        num_r[i] <= {num_r[i][17:0], 1'b0};
      end
    end
  end

  // With fog on the quotient never exceeds 255, so the low 8 bits hold it
  assign pix_color = status.fog_on ? {quo_r[2], quo_r[1], quo_r[0]} : src;
endmodule

[design/tcs_ctrl.sv]
// ----------------------------------------------------------------------------
// tcs_ctrl
// Sequencer: decode commands, run the fog divider, hold the result.
// ----------------------------------------------------------------------------
module tcs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tcs_pkg::tcs_status_t status,
  output tcs_pkg::tcs_cmd_t    cmd
);
  import tcs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       acc;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign acc       = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.tex_write = in_cmd == CMD_WRITE;
          cmd.col_start = in_cmd == CMD_START;
          if (in_cmd == CMD_EMIT && status.row_left) begin
            cmd.emit = 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.div_start = 1'b1;
        cnt_nxt = '0;
        state_nxt = status.fog_on ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

[design/textured_column_shader_unit.sv]
// ----------------------------------------------------------------------------
// textured_column_shader_unit
// Textured wall column shader with distance fog.
// ----------------------------------------------------------------------------
// Texel write, column start, cmd 3 and empty emit: one transfer per cycle while idle.
// Pixel emit: the input transfer registers the texel read and enters S_LOAD,
// which starts the 19-step restoring divider and goes to S_OUT without fog,
// or through S_DIV with fog; the next input is taken after S_OUT, once
// out_ready takes the result. Reset (rst_n low, synchronous) clears control
// and column state; the texture memory is undefined until written.
module textured_column_shader_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [1:0]  in_wall_side,
  input  logic [5:0]  in_tex_col,
  input  logic [5:0]  in_tex_row,
  input  logic [23:0] in_texel,
  input  logic [9:0]  in_screen_col,
  input  logic [9:0]  in_row_start,
  input  logic [10:0] in_row_end,
  input  logic [31:0] in_tex_pos,
  input  logic [31:0] in_tex_step,
  input  logic [23:0] in_distance,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_pixel_x,
  output logic [9:0]  out_pixel_y,
  output logic [23:0] out_color,
  output logic        out_last
);
  import tcs_pkg::*;
  `include "assert_macros.svh"

  tcs_cmd_t    cmd;
  tcs_status_t status;

  tcs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd,
    .out_valid, .out_ready, .status, .cmd
  );

  tcs_datapath u_dp (
    .clk, .cmd, .rst_n, .in_wall_side, .in_tex_col, .in_tex_row, .in_texel,
    .in_screen_col, .in_row_start, .in_row_end, .in_tex_pos, .in_tex_step,
    .in_distance, .status,
    .pix_x(out_pixel_x), .pix_y(out_pixel_y), .pix_color(out_color),
    .pix_last(out_last)
  );

  `ASSERT_NEVER(a_no_overlap, clk, rst_n, in_ready && out_valid, "ready while result held")
  `ASSERT_IMPL(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_color), "result dropped")
  `ASSERT_NEVER(a_one_cmd, clk, rst_n, !$onehot0(cmd), "multiple commands")
endmodule
